// ----- hdl/espc_pkg.sv -----
// Shared types, codes and constants of the equal-sum partition checker.
package espc_pkg;

  localparam int unsigned MAX_HALF_SUM_DEF = 1023;
  localparam int unsigned WORD_BITS_DEF    = 64;

  localparam int unsigned WEIGHT_W    = 16;
  localparam int unsigned TOTAL_W     = 24;
  // Widest bit offset inside a bitset word over the supported word sizes.
  localparam int unsigned OFF_W_MAX   = 6;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    ST_DECIDED = 2'd0,
    ST_ODD     = 2'd1,
    ST_RANGE   = 2'd2
  } status_e;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic                last;
  } item_t;

  typedef struct packed {
    logic    can_partition;
    status_e status;
  } result_t;

  // One classified item handed from the front end to the bitset engine.
  typedef struct packed {
    logic                 shift_en;
    logic                 last;
    status_e              status;
    logic [WEIGHT_W-1:0]  wq;
    logic [OFF_W_MAX-1:0] wr;
    logic [WEIGHT_W-1:0]  hq;
    logic [OFF_W_MAX-1:0] hr;
  } job_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIVW,
    F_DIVH,
    F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SWEEP,
    B_DRAIN,
    B_QUERY,
    B_RESULT
  } back_state_e;

endpackage

// ----- hdl/espc_front.sv -----
// Front end: accepts items, keeps the running total and splits offsets into word and bit.
module espc_front import espc_pkg::*; #(
  parameter int unsigned MAX_HALF_SUM = MAX_HALF_SUM_DEF,
  parameter int unsigned WORD_BITS    = WORD_BITS_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  output logic  job_push_o,
  output job_t  job_o,
  input  logic  job_full_i
);

  localparam int unsigned OFF_W = $clog2(WORD_BITS);
  localparam logic [WEIGHT_W-1:0] WB_W     = WEIGHT_W'(WORD_BITS);
  localparam logic [WEIGHT_W-1:0] HALF_W_MAX = WEIGHT_W'(MAX_HALF_SUM);
  localparam logic [TOTAL_W-1:0]  HALF_T_MAX = TOTAL_W'(MAX_HALF_SUM);
  localparam int unsigned MUL_W  = WEIGHT_W + 2;
  localparam int unsigned PROD_W = WEIGHT_W + MUL_W;
  localparam int unsigned DIV_S  = WEIGHT_W + OFF_W;
  // Reciprocal of WORD_BITS rounded up; exact for every dividend of WEIGHT_W bits.
  localparam logic [MUL_W-1:0] DIV_M = MUL_W'(((1 << DIV_S) + WORD_BITS - 1) / WORD_BITS);

  front_state_e        state_q, state_d;
  logic [TOTAL_W-1:0]  total_q, total_d;
  logic                sat_q, sat_d;
  job_t                job_q, job_d;
  logic [WEIGHT_W-1:0] rem_q, rem_d;
  logic [WEIGHT_W-1:0] half_q, half_d;

  logic [TOTAL_W:0]    sum;
  logic [TOTAL_W-1:0]  tot_nx;
  logic                sat_nx;
  logic [TOTAL_W-1:0]  half_t;
  status_e             status_nx;
  logic                shift_en;
  logic [PROD_W-1:0]   prod;
  logic [WEIGHT_W-1:0] div_quo;
  logic [WEIGHT_W-1:0] div_rem;

  assign sum    = {1'b0, total_q} + (TOTAL_W+1)'(item_i.weight);
  assign tot_nx = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
  assign sat_nx = sat_q | sum[TOTAL_W];
  assign half_t = tot_nx >> 1;

  always_comb begin
    if (sat_nx) begin
      status_nx = ST_RANGE;
    end else if (tot_nx[0]) begin
      status_nx = ST_ODD;
    end else if (half_t > HALF_T_MAX) begin
      status_nx = ST_RANGE;
    end else begin
      status_nx = ST_DECIDED;
    end
  end

  // Weights of zero or beyond the bitset leave the reachable sums untouched.
  assign shift_en = (item_i.weight != '0) && (item_i.weight <= HALF_W_MAX);

  // Word index and bit offset of the registered offset, by reciprocal multiplication.
  assign prod    = PROD_W'(rem_q) * PROD_W'(DIV_M);
  assign div_quo = WEIGHT_W'(prod >> DIV_S);
  assign div_rem = rem_q - div_quo * WB_W;

  always_comb begin
    state_d    = state_q;
    total_d    = total_q;
    sat_d      = sat_q;
    job_d      = job_q;
    rem_d      = rem_q;
    half_d     = half_q;
    job_push_o = 1'b0;
    unique case (state_q)
      F_IDLE: begin
        if (push_i) begin
          total_d        = item_i.last ? '0 : tot_nx;
          sat_d          = item_i.last ? 1'b0 : sat_nx;
          job_d.shift_en = shift_en;
          job_d.last     = item_i.last;
          job_d.status   = item_i.last ? status_nx : ST_DECIDED;
          job_d.wq       = '0;
          job_d.wr       = '0;
          job_d.hq       = '0;
          job_d.hr       = '0;
          half_d         = half_t[WEIGHT_W-1:0];
          rem_d          = item_i.weight;
          if (shift_en) begin
            state_d = F_DIVW;
          end else if (item_i.last && (status_nx == ST_DECIDED)) begin
            rem_d   = half_t[WEIGHT_W-1:0];
            state_d = F_DIVH;
          end else begin
            state_d = F_PUSH;
          end
        end
      end
      F_DIVW: begin
        job_d.wq = div_quo;
        job_d.wr = OFF_W_MAX'(div_rem[OFF_W-1:0]);
        if (job_q.last && (job_q.status == ST_DECIDED)) begin
          rem_d   = half_q;
          state_d = F_DIVH;
        end else begin
          state_d = F_PUSH;
        end
      end
      F_DIVH: begin
        job_d.hq = div_quo;
        job_d.hr = OFF_W_MAX'(div_rem[OFF_W-1:0]);
        state_d  = F_PUSH;
      end
      F_PUSH: begin
        if (!job_full_i) begin
          job_push_o = 1'b1;
          state_d    = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      total_q <= '0;
      sat_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      sat_q   <= sat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    rem_q  <= rem_d;
    half_q <= half_d;
  end

  assign full_o = (state_q != F_IDLE);
  assign job_o  = job_q;

endmodule

// ----- hdl/espc_fifo.sv -----
// Short queue of classified items between the front end and the bitset engine.
module espc_fifo import espc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output job_t data_o,
  output logic empty_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  job_t             buf_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_FULL);
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = buf_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- hdl/espc_back.sv -----
// Bitset engine: word-serial shift-or over the reachable sums, final lookup and result register.
module espc_back import espc_pkg::*; #(
  parameter int unsigned MAX_HALF_SUM = MAX_HALF_SUM_DEF,
  parameter int unsigned WORD_BITS    = WORD_BITS_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    job_empty_i,
  output logic    job_pop_o,
  input  job_t    job_i,
  output logic    res_empty_o,
  input  logic    res_pop_i,
  output result_t res_o
);

  localparam int unsigned NW       = (MAX_HALF_SUM + WORD_BITS) / WORD_BITS;
  localparam int unsigned IDX_W    = (NW > 1) ? $clog2(NW) : 1;
  localparam int unsigned CNT_W    = $clog2(NW + 1);
  localparam int unsigned CW1      = CNT_W + 1;
  localparam int unsigned OFF_W    = $clog2(WORD_BITS);
  localparam int unsigned SH_W     = OFF_W + 1;
  localparam int unsigned TOP_BITS = MAX_HALF_SUM + 1 - (NW - 1) * WORD_BITS;
  localparam logic [WORD_BITS-1:0] TOP_MASK = {WORD_BITS{1'b1}} >> (WORD_BITS - TOP_BITS);
  localparam logic [CW1-1:0]   NW_C   = CW1'(NW);
  localparam logic [CW1-1:0]   NW_M1  = CW1'(NW - 1);
  localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(NW - 1);
  localparam logic [SH_W-1:0]  WB_SH  = SH_W'(WORD_BITS);

  back_state_e          state_q, state_d;
  job_t                 job_q, job_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;

  logic [WORD_BITS-1:0] mem_q [NW];
  logic [NW-1:0]        vld_q;

  logic [WORD_BITS-1:0] a_raw_q, b_raw_q, a_prev_q;
  logic                 a_vld_q, a_zero_q, a_idx0_q;
  logic                 b_vld_q, b_idx0_q;
  logic                 wr_pend_q, wr_pend_d;
  logic [IDX_W-1:0]     wr_idx_q;

  logic                 out_valid_q;
  result_t              out_q, out_d;
  logic                 out_load, clear_vld;

  logic                 rd_a_en, rd_b_en, a_zero_d;
  logic [IDX_W-1:0]     rd_a_idx;
  logic [CW1-1:0]       qc, src_sum, src_full, dst_full;
  logic                 src_ok, last_rd;
  logic [IDX_W-1:0]     src_idx, dst_idx;
  logic [OFF_W-1:0]     r;
  logic [WORD_BITS-1:0] a_eff, b_eff, shifted, wr_data;
  logic                 hit;

  // Destination word k takes source words k-q (upper part) and k-q-1 (lower part).
  assign qc       = CW1'(job_q.wq[IDX_W-1:0]);
  assign src_sum  = qc + CW1'(cnt_q);
  assign src_ok   = src_sum <= NW_M1;
  assign src_full = NW_M1 - src_sum;
  assign src_idx  = src_full[IDX_W-1:0];
  assign dst_full = NW_C - CW1'(cnt_q);
  assign dst_idx  = dst_full[IDX_W-1:0];
  assign last_rd  = src_sum == NW_C;
  assign r        = job_q.wr[OFF_W-1:0];

  // A word that was never written since the last clear holds the empty-set value.
  assign a_eff = a_zero_q ? '0 : (a_vld_q ? a_raw_q : (a_idx0_q ? WORD_BITS'(1) : '0));
  assign b_eff = b_vld_q ? b_raw_q : (b_idx0_q ? WORD_BITS'(1) : '0);

  assign shifted = (a_prev_q << r) | ((r != '0) ? (a_eff >> (WB_SH - SH_W'(r))) : '0);
  assign wr_data = (wr_idx_q == IDX_TOP) ? ((b_eff | shifted) & TOP_MASK) : (b_eff | shifted);
  assign hit     = a_eff[job_q.hr[OFF_W-1:0]];

  always_comb begin
    state_d   = state_q;
    job_d     = job_q;
    cnt_d     = cnt_q;
    job_pop_o = 1'b0;
    rd_a_en   = 1'b0;
    rd_b_en   = 1'b0;
    rd_a_idx  = src_idx;
    a_zero_d  = !src_ok;
    wr_pend_d = 1'b0;
    out_load  = 1'b0;
    clear_vld = 1'b0;
    out_d     = out_q;
    unique case (state_q)
      B_IDLE: begin
        if (!job_empty_i) begin
          job_pop_o = 1'b1;
          job_d     = job_i;
          cnt_d     = '0;
          if (job_i.shift_en) begin
            state_d = B_SWEEP;
          end else if (job_i.last) begin
            state_d = B_QUERY;
          end
        end
      end
      B_SWEEP: begin
        rd_a_en   = 1'b1;
        rd_b_en   = (cnt_q != '0);
        wr_pend_d = (cnt_q != '0);
        if (last_rd) begin
          state_d = B_DRAIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      B_DRAIN: begin
        state_d = job_q.last ? B_QUERY : B_IDLE;
      end
      B_QUERY: begin
        rd_a_en  = 1'b1;
        rd_a_idx = job_q.hq[IDX_W-1:0];
        a_zero_d = 1'b0;
        state_d  = B_RESULT;
      end
      B_RESULT: begin
        if (!out_valid_q || res_pop_i) begin
          out_load            = 1'b1;
          clear_vld           = 1'b1;
          out_d.can_partition = (job_q.status == ST_DECIDED) && hit;
          out_d.status        = job_q.status;
          state_d             = B_IDLE;
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      vld_q       <= '0;
      wr_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      wr_pend_q <= wr_pend_d;
      if (clear_vld) begin
        vld_q <= '0;
      end else if (wr_pend_q) begin
        vld_q[wr_idx_q] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (res_pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    job_q    <= job_d;
    cnt_q    <= cnt_d;
    wr_idx_q <= dst_idx;
    out_q    <= out_d;
    if (state_q == B_SWEEP) begin
      a_prev_q <= a_eff;
    end
    if (rd_a_en) begin
      a_raw_q  <= mem_q[rd_a_idx];
      a_vld_q  <= vld_q[rd_a_idx];
      a_zero_q <= a_zero_d;
      a_idx0_q <= (rd_a_idx == '0);
    end
    if (rd_b_en) begin
      b_raw_q  <= mem_q[dst_idx];
      b_vld_q  <= vld_q[dst_idx];
      b_idx0_q <= (dst_idx == '0);
    end
    if (wr_pend_q) begin
      mem_q[wr_idx_q] <= wr_data;
    end
  end

  assign res_empty_o = !out_valid_q;
  assign res_o       = out_q;

endmodule

// ----- hdl/equal_sum_partition_check.sv -----
// Equal-sum partition checker: reports whether a set of weights splits into two equal halves.
//
// Input channel: present item_i (weight, last) with push; it is taken at a rising edge with
// push high and full low. The last item of a set must carry last = 1.
// Result channel: one result per set, on res_o while empty is low, taken with pop.
// status 0 means decided, 1 an odd total, 2 a half sum beyond the bitset or a saturated total;
// can_partition is 1 only with status 0 and half the total reachable.
// The front end holds full high after taking an item until it has pushed it to the queue:
// it divides the offset of a weight in range (F_DIVW), then the half sum of a decided last item
// (F_DIVH), then pushes (F_PUSH), and stays longer while the queue behind it is full.
// The bitset engine sweeps NW = (MAX_HALF_SUM + WORD_BITS) / WORD_BITS words from the top down,
// one word a cycle on a dual-read memory, for each weight in range, then drains; a last item
// then goes through the lookup and the result state.
// An unpopped result holds the engine once the next result is ready; the two-entry queue
// and the front end take items until they fill up; full then stays high until the receiver pops.
// Reset clears the total, the queue, the result valid flag and the per-word valid bits at once,
// so the bitset reads as only sum zero reachable; no clearing pass is needed.
module equal_sum_partition_check import espc_pkg::*; #(
  parameter int unsigned MAX_HALF_SUM = MAX_HALF_SUM_DEF,
  parameter int unsigned WORD_BITS    = WORD_BITS_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push,
  input  item_t   item_i,
  output logic    full,
  output logic    empty,
  input  logic    pop,
  output result_t res_o
);

  logic job_push, job_full, job_pop, job_empty;
  job_t job_in, job_out;

  espc_front #(
    .MAX_HALF_SUM (MAX_HALF_SUM),
    .WORD_BITS    (WORD_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .item_i     (item_i),
    .full_o     (full),
    .job_push_o (job_push),
    .job_o      (job_in),
    .job_full_i (job_full)
  );

  espc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .data_o  (job_out),
    .empty_o (job_empty)
  );

  espc_back #(
    .MAX_HALF_SUM (MAX_HALF_SUM),
    .WORD_BITS    (WORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_empty_i (job_empty),
    .job_pop_o   (job_pop),
    .job_i       (job_out),
    .res_empty_o (empty),
    .res_pop_i   (pop),
    .res_o       (res_o)
  );

`ifndef ASSERT_OFF
  a_no_queue_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_push |-> !job_full)
    else $error("item pushed into a full queue");

  a_no_queue_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop |-> !job_empty)
    else $error("item popped from an empty queue");

  a_front_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |=> full)
    else $error("front end not busy after taking an item");

  a_undecided_never_true: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (res_o.status != ST_DECIDED)) |-> !res_o.can_partition)
    else $error("partition reported true for an undecided set");
`endif

endmodule
